// File: hdl/tpt_pkg.sv
`default_nettype none

package tpt_pkg;

  // Field widths fixed by the packet and report formats.
  localparam int POS_X_W    = 14;
  localparam int POS_Y_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int PROD_W     = 16;
  localparam int SUM_W      = 17;

  // Default geometry and timer width.
  localparam int PAD_WIDTH_DEF  = 11264;
  localparam int PAD_HEIGHT_DEF = 6656;
  localparam int TIME_BITS_DEF  = 32;

  // Result queue depth.
  localparam int OUTQ_DEPTH = 4;

  // Packet type codes carried in the fourth byte.
  localparam logic [7:0] KIND_ABS        = 8'hf8;
  localparam logic [7:0] KIND_REL        = 8'h00;
  localparam logic [7:0] KIND_SCR_UP     = 8'hd5;
  localparam logic [7:0] KIND_SCR_DOWN   = 8'h2b;
  localparam logic [7:0] KIND_SCR_LEFT   = 8'hd6;
  localparam logic [7:0] KIND_SCR_RIGHT  = 8'h2a;

  // Request type codes.
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MS = 3'd4;

  // Configuration reset values.
  localparam logic [7:0] X_SCALE_RST    = 8'd44;
  localparam logic [7:0] Y_SCALE_RST    = 8'd26;
  localparam logic [5:0] REL_GAIN_RST   = 6'd11;
  localparam logic [9:0] TAP_GAP_RST    = 10'd64;
  localparam logic [9:0] RELEASE_MS_RST = 10'd32;

  // Decoded operation codes.
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ABS       = 3'd1;
  localparam logic [2:0] OP_REL       = 3'd2;
  localparam logic [2:0] OP_SCR_UP    = 3'd3;
  localparam logic [2:0] OP_SCR_DOWN  = 3'd4;
  localparam logic [2:0] OP_SCR_LEFT  = 3'd5;
  localparam logic [2:0] OP_SCR_RIGHT = 3'd6;
  localparam logic [2:0] OP_OTHER     = 3'd7;

  typedef struct packed {
    logic       req_type;
    logic [7:0] status_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [7:0] kind_byte;
  } tpt_in_t;

  typedef struct packed {
    logic [POS_X_W-1:0] pos_x_out;
    logic [POS_Y_W-1:0] pos_y_out;
    logic               left_button;
    logic               right_button;
    logic               touching;
    logic               scroll_up;
    logic               scroll_down;
    logic               scroll_left;
    logic               scroll_right;
    logic               last_of_run;
  } tpt_out_t;

  typedef struct packed {
    logic [7:0] x_scale;
    logic [7:0] y_scale;
    logic [5:0] rel_gain;
    logic [9:0] tap_gap_ms;
    logic [9:0] release_ms;
  } tpt_cfg_t;

  typedef struct packed {
    logic [2:0]        op;
    logic              left;
    logic              right;
    logic [PROD_W-1:0] abs_x;
    logic [PROD_W-1:0] abs_y;
    logic [PROD_W-1:0] rel_dx;
    logic [PROD_W-1:0] rel_dy;
  } tpt_dec_t;

  typedef struct packed {
    logic vld0;
    logic vld1;
  } tpt_push_t;

endpackage

`default_nettype wire

// File: hdl/tpt_front.sv
`default_nettype none

module tpt_front
  import tpt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire tpt_in_t  in_data,
  output logic          in_stall,
  input  wire tpt_cfg_t cfg,
  input  wire logic     adv,
  output logic          dec_vld_r,
  output tpt_dec_t      dec_r
);

  logic                    accept;
  logic                    dec_vld_nxt;
  tpt_dec_t                dec_nxt;
  logic signed [9:0]       dx;
  logic signed [9:0]       dy;
  logic signed [SUM_W-1:0] prod_dx;
  logic signed [SUM_W-1:0] prod_dy;

  // The stage holds one item until the core takes it.
  assign in_stall = dec_vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  // Nine-bit signed deltas; a zero magnitude ignores the sign bit.
  always_comb begin
    if (in_data.x_byte == 8'd0) begin
      dx = 10'sd0;
    end else begin
      dx = $signed({2'b00, in_data.x_byte}) -
           $signed({1'b0, in_data.status_byte[4], 8'd0});
    end
    if (in_data.y_byte == 8'd0) begin
      dy = 10'sd0;
    end else begin
      dy = $signed({1'b0, in_data.status_byte[5], 8'd0}) -
           $signed({2'b00, in_data.y_byte});
    end
    prod_dx = SUM_W'(dx) * SUM_W'($signed({1'b0, cfg.rel_gain}));
    prod_dy = SUM_W'(dy) * SUM_W'($signed({1'b0, cfg.rel_gain}));
  end

  // Decode the operation and form the scaled products.
  always_comb begin
    dec_nxt.left   = in_data.status_byte[0];
    dec_nxt.right  = in_data.status_byte[1];
    dec_nxt.abs_x  = {8'd0, in_data.x_byte} * {8'd0, cfg.x_scale};
    dec_nxt.abs_y  = {8'd0, ~in_data.y_byte} * {8'd0, cfg.y_scale};
    dec_nxt.rel_dx = prod_dx[PROD_W-1:0];
    dec_nxt.rel_dy = prod_dy[PROD_W-1:0];
    if (in_data.req_type == REQ_TICK) begin
      dec_nxt.op = OP_TICK;
    end else begin
      unique case (in_data.kind_byte)
        KIND_ABS:       dec_nxt.op = OP_ABS;
        KIND_REL:       dec_nxt.op = OP_REL;
        KIND_SCR_UP:    dec_nxt.op = OP_SCR_UP;
        KIND_SCR_DOWN:  dec_nxt.op = OP_SCR_DOWN;
        KIND_SCR_LEFT:  dec_nxt.op = OP_SCR_LEFT;
        KIND_SCR_RIGHT: dec_nxt.op = OP_SCR_RIGHT;
        default:        dec_nxt.op = OP_OTHER;
      endcase
    end
  end

  // Valid flag of the stage.
  always_comb begin
    if (accept) begin
      dec_vld_nxt = 1'b1;
    end else if (adv) begin
      dec_vld_nxt = 1'b0;
    end else begin
      dec_vld_nxt = dec_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_vld_r <= 1'b0;
    end else begin
      dec_vld_r <= dec_vld_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tpt_core.sv
`default_nettype none

module tpt_core
  import tpt_pkg::*;
#(
  parameter int PAD_WIDTH  = PAD_WIDTH_DEF,
  parameter int PAD_HEIGHT = PAD_HEIGHT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     dec_vld,
  input  wire tpt_dec_t dec,
  input  wire tpt_cfg_t cfg,
  input  wire logic     room,
  output logic          adv,
  output tpt_push_t     push,
  output tpt_out_t      res0,
  output tpt_out_t      res1
);

  localparam logic [PROD_W-1:0]  PAD_X16 = PROD_W'(PAD_WIDTH);
  localparam logic [PROD_W-1:0]  PAD_Y16 = PROD_W'(PAD_HEIGHT);
  localparam logic [POS_X_W-1:0] PAD_X   = POS_X_W'(PAD_WIDTH);
  localparam logic [POS_Y_W-1:0] PAD_Y   = POS_Y_W'(PAD_HEIGHT);

  logic [TIME_BITS-1:0] ms_r, ms_nxt;
  logic [TIME_BITS-1:0] last_touch_r, last_touch_nxt;
  logic [TIME_BITS-1:0] gap;
  logic                 gap_over;
  logic [9:0]           cnt_r, cnt_nxt;
  logic                 armed_r, armed_nxt;
  logic [POS_X_W-1:0]   pos_x_r, pos_x_nxt;
  logic [POS_Y_W-1:0]   pos_y_r, pos_y_nxt;
  logic                 left_r, left_nxt;
  logic                 right_r, right_nxt;
  logic                 touch_r, touch_nxt;
  logic [SUM_W-1:0]     sum_x;
  logic [SUM_W-1:0]     sum_y;
  logic [POS_X_W-1:0]   rel_x;
  logic [POS_Y_W-1:0]   rel_y;
  logic [POS_X_W-1:0]   abs_x;
  logic [POS_Y_W-1:0]   abs_y;
  logic                 emit0;
  logic                 two;
  logic [3:0]           scr;
  tpt_out_t             base;

  assign adv = dec_vld && room;

  // Time since the last touch, modulo the timer width.
  assign gap      = ms_r - last_touch_r;
  assign gap_over = gap > TIME_BITS'(cfg.tap_gap_ms);

  // Relative move: add the scaled delta and saturate to the pad.
  assign sum_x = {3'b000, pos_x_r} + {dec.rel_dx[PROD_W-1], dec.rel_dx};
  assign sum_y = {4'b0000, pos_y_r} + {dec.rel_dy[PROD_W-1], dec.rel_dy};

  always_comb begin
    if (sum_x[SUM_W-1]) begin
      rel_x = '0;
    end else if (sum_x[PROD_W-1:0] > PAD_X16) begin
      rel_x = PAD_X;
    end else begin
      rel_x = sum_x[POS_X_W-1:0];
    end
    if (sum_y[SUM_W-1]) begin
      rel_y = '0;
    end else if (sum_y[PROD_W-1:0] > PAD_Y16) begin
      rel_y = PAD_Y;
    end else begin
      rel_y = sum_y[POS_Y_W-1:0];
    end
  end

  // Absolute seed, saturated to the pad.
  assign abs_x = (dec.abs_x > PAD_X16) ? PAD_X : dec.abs_x[POS_X_W-1:0];
  assign abs_y = (dec.abs_y > PAD_Y16) ? PAD_Y : dec.abs_y[POS_Y_W-1:0];

  // Next state and which reports the item makes.
  always_comb begin
    ms_nxt         = ms_r;
    last_touch_nxt = last_touch_r;
    cnt_nxt        = cnt_r;
    armed_nxt      = armed_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    touch_nxt      = touch_r;
    emit0          = 1'b1;
    two            = 1'b0;
    scr            = 4'b0000;

    unique case (dec.op)
      OP_TICK: begin
        ms_nxt = ms_r + TIME_BITS'(1);
        emit0  = 1'b0;
        if (armed_r) begin
          if (cnt_r <= 10'd1) begin
            cnt_nxt   = 10'd0;
            armed_nxt = 1'b0;
            touch_nxt = 1'b0;
            emit0     = 1'b1;
          end else begin
            cnt_nxt = cnt_r - 10'd1;
          end
        end
      end
      OP_ABS: begin
        if (!touch_r) begin
          left_nxt  = dec.left;
          right_nxt = dec.right;
          pos_x_nxt = abs_x;
          pos_y_nxt = abs_y;
          if (gap_over) begin
            touch_nxt = 1'b1;
          end
        end
      end
      OP_REL: begin
        left_nxt  = dec.left;
        right_nxt = dec.right;
        pos_x_nxt = rel_x;
        pos_y_nxt = rel_y;
        touch_nxt = 1'b1;
      end
      OP_SCR_UP: begin
        two = 1'b1;
        scr = 4'b1000;
      end
      OP_SCR_DOWN: begin
        two = 1'b1;
        scr = 4'b0100;
      end
      OP_SCR_LEFT: begin
        two = 1'b1;
        scr = 4'b0010;
      end
      OP_SCR_RIGHT: begin
        two = 1'b1;
        scr = 4'b0001;
      end
      OP_OTHER: begin
        two = 1'b0;
      end
      default: begin
        two = 1'b0;
      end
    endcase

    // Every packet that leaves the finger down rearms the release timer.
    if (dec.op != OP_TICK && touch_nxt) begin
      last_touch_nxt = ms_r;
      cnt_nxt        = cfg.release_ms;
      armed_nxt      = 1'b1;
    end
  end

  // Reports show the state after the item.
  always_comb begin
    base.pos_x_out    = pos_x_nxt;
    base.pos_y_out    = pos_y_nxt;
    base.left_button  = left_nxt;
    base.right_button = right_nxt;
    base.touching     = touch_nxt;
    base.scroll_up    = 1'b0;
    base.scroll_down  = 1'b0;
    base.scroll_left  = 1'b0;
    base.scroll_right = 1'b0;
    base.last_of_run  = 1'b1;
    res1 = base;
    res0 = base;
    if (two) begin
      res0.scroll_up    = scr[3];
      res0.scroll_down  = scr[2];
      res0.scroll_left  = scr[1];
      res0.scroll_right = scr[0];
      res0.last_of_run  = 1'b0;
    end
    push.vld0 = adv && emit0;
    push.vld1 = adv && two;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r         <= '0;
      last_touch_r <= '0;
      cnt_r        <= '0;
      armed_r      <= 1'b0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      left_r       <= 1'b0;
      right_r      <= 1'b0;
      touch_r      <= 1'b0;
    end else if (adv) begin
      ms_r         <= ms_nxt;
      last_touch_r <= last_touch_nxt;
      cnt_r        <= cnt_nxt;
      armed_r      <= armed_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      touch_r      <= touch_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tpt_outq.sv
`default_nettype none

module tpt_outq
  import tpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire tpt_push_t push,
  input  wire tpt_out_t  res0,
  input  wire tpt_out_t  res1,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_stall,
  output tpt_out_t       out_data
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  tpt_out_t         mem [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_add;
  logic             pop;

  // Room for the two reports that one item can make.
  assign room      = count_r <= CNT_W'(OUTQ_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // Pointer and fill count update.
  always_comb begin
    n_add      = CNT_W'(push.vld0) + CNT_W'(push.vld1);
    count_nxt  = count_r + n_add - CNT_W'(pop);
    wr_ptr_nxt = wr_ptr_r + n_add[PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Report storage; the second report goes in behind the first.
  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem[wr_ptr_r] <= res0;
    end
    if (push.vld1) begin
      mem[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/touchpad_packet_tracker_unit.sv
// Flow: an accepted item is decoded into the input register; the core then takes it and
// pushes its reports into the report queue, which offers them on the output port.
// Throughput: one item per cycle while each item makes at most one report and the output
// is not stalled; a scroll packet makes two reports, which the single output port passes
// on one at a time.
// Reset: synchronous, active low; clears the tracker state, empties the report queue
// and loads the configuration defaults.
`default_nettype none

module touchpad_packet_tracker_unit
  import tpt_pkg::*;
#(
  parameter int PAD_WIDTH  = PAD_WIDTH_DEF,
  parameter int PAD_HEIGHT = PAD_HEIGHT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tpt_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tpt_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  tpt_cfg_t  cfg_r;
  logic      dec_vld;
  tpt_dec_t  dec;
  logic      adv;
  logic      room;
  tpt_push_t push;
  tpt_out_t  res0;
  tpt_out_t  res1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_scale    <= X_SCALE_RST;
      cfg_r.y_scale    <= Y_SCALE_RST;
      cfg_r.rel_gain   <= REL_GAIN_RST;
      cfg_r.tap_gap_ms <= TAP_GAP_RST;
      cfg_r.release_ms <= RELEASE_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_X_SCALE:    cfg_r.x_scale    <= cfg_data[7:0];
        CFG_Y_SCALE:    cfg_r.y_scale    <= cfg_data[7:0];
        CFG_REL_GAIN:   cfg_r.rel_gain   <= cfg_data[5:0];
        CFG_TAP_GAP:    cfg_r.tap_gap_ms <= cfg_data;
        CFG_RELEASE_MS: cfg_r.release_ms <= cfg_data;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // Input register with decode and scaling.
  tpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg       (cfg_r),
    .adv       (adv),
    .dec_vld_r (dec_vld),
    .dec_r     (dec)
  );

  // Tracker state and report generation.
  tpt_core #(
    .PAD_WIDTH  (PAD_WIDTH),
    .PAD_HEIGHT (PAD_HEIGHT),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .dec_vld (dec_vld),
    .dec     (dec),
    .cfg     (cfg_r),
    .room    (room),
    .adv     (adv),
    .push    (push),
    .res0    (res0),
    .res1    (res1)
  );

  // Report queue in front of the output port.
  tpt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A second report only follows a first one that carries one scroll flag.
  a_scroll_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld1 |-> push.vld0 && !res0.last_of_run &&
      $onehot({res0.scroll_up, res0.scroll_down, res0.scroll_left, res0.scroll_right}))
    else $error("scroll report pair malformed");

  // A single report always closes the item's run.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.vld0 && !push.vld1) |-> res0.last_of_run)
    else $error("single report not marked last");

  // Reports are only made for an item taken by the core.
  a_push_adv: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld0 |-> adv && dec_vld)
    else $error("report without an item");

  // The queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
  import tpt_pkg::*;

  // The timer is built at 12 bits, narrower than its default width.
  localparam int TB_TIME_BITS = 12;
  localparam logic [31:0] TIME_MASK = (32'd1 << TB_TIME_BITS) - 32'd1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int LONG_RUN_MAX = 100;

  // Scroll direction carried by one report.
  typedef enum int {SCR_NONE, SCR_UP, SCR_DOWN, SCR_LEFT, SCR_RIGHT} scroll_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tpt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tpt_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  touchpad_packet_tracker_unit #(
    .TIME_BITS(TB_TIME_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Tracker copy: configuration and state.
  logic [7:0] cfg_x_scale;
  logic [7:0] cfg_y_scale;
  logic [5:0] cfg_rel_gain;
  logic [9:0] cfg_tap_gap;
  logic [9:0] cfg_release;
  logic [31:0] trk_ms;
  logic [31:0] trk_last_touch;
  logic [9:0] trk_countdown;
  logic trk_armed;
  int trk_pos_x;
  int trk_pos_y;
  logic trk_left;
  logic trk_right;
  logic trk_touch;

  tpt_in_t queued_requests[$];
  tpt_out_t expected_reports[$];

  int fail_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int recv_calm = 0;
  logic item_taken;
  tpt_out_t want;

  task automatic reset_tracker();
    cfg_x_scale = X_SCALE_RST;
    cfg_y_scale = Y_SCALE_RST;
    cfg_rel_gain = REL_GAIN_RST;
    cfg_tap_gap = TAP_GAP_RST;
    cfg_release = RELEASE_MS_RST;
    trk_ms = '0;
    trk_last_touch = '0;
    trk_countdown = '0;
    trk_armed = 1'b0;
    trk_pos_x = 0;
    trk_pos_y = 0;
    trk_left = 1'b0;
    trk_right = 1'b0;
    trk_touch = 1'b0;
  endtask

  function automatic int clamp_pos(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic tpt_out_t make_report(scroll_t scr, logic last);
    tpt_out_t r;
    r.pos_x_out = trk_pos_x[POS_X_W-1:0];
    r.pos_y_out = trk_pos_y[POS_Y_W-1:0];
    r.left_button = trk_left;
    r.right_button = trk_right;
    r.touching = trk_touch;
    r.scroll_up = (scr == SCR_UP);
    r.scroll_down = (scr == SCR_DOWN);
    r.scroll_left = (scr == SCR_LEFT);
    r.scroll_right = (scr == SCR_RIGHT);
    r.last_of_run = last;
    return r;
  endfunction

  // Advance the tracker copy by one item and queue the reports it causes.
  task automatic predict_reports(input tpt_in_t it);
    scroll_t scr;
    int dx;
    int dy;
    scr = SCR_NONE;
    if (it.req_type == REQ_TICK) begin
      trk_ms = (trk_ms + 32'd1) & TIME_MASK;
      if (trk_armed) begin
        if (trk_countdown <= 10'd1) begin
          trk_countdown = '0;
          trk_armed = 1'b0;
          trk_touch = 1'b0;
          expected_reports.push_back(make_report(SCR_NONE, 1'b1));
        end else begin
          trk_countdown = trk_countdown - 10'd1;
        end
      end
    end else begin
      case (it.kind_byte)
        KIND_ABS: begin
          if (!trk_touch) begin
            trk_left = it.status_byte[0];
            trk_right = it.status_byte[1];
            trk_pos_x = clamp_pos(int'(it.x_byte) * int'(cfg_x_scale), PAD_WIDTH_DEF);
            trk_pos_y = clamp_pos((255 - int'(it.y_byte)) * int'(cfg_y_scale),
                                  PAD_HEIGHT_DEF);
            if (((trk_ms - trk_last_touch) & TIME_MASK) > 32'(cfg_tap_gap))
              trk_touch = 1'b1;
          end
        end
        KIND_REL: begin
          trk_left = it.status_byte[0];
          trk_right = it.status_byte[1];
          dx = 0;
          dy = 0;
          if (it.x_byte != 8'd0) dx = int'(it.x_byte) - (it.status_byte[4] ? 256 : 0);
          if (it.y_byte != 8'd0) dy = (it.status_byte[5] ? 256 : 0) - int'(it.y_byte);
          trk_pos_x = clamp_pos(trk_pos_x + dx * int'(cfg_rel_gain), PAD_WIDTH_DEF);
          trk_pos_y = clamp_pos(trk_pos_y + dy * int'(cfg_rel_gain), PAD_HEIGHT_DEF);
          trk_touch = 1'b1;
        end
        KIND_SCR_UP: scr = SCR_UP;
        KIND_SCR_DOWN: scr = SCR_DOWN;
        KIND_SCR_LEFT: scr = SCR_LEFT;
        KIND_SCR_RIGHT: scr = SCR_RIGHT;
        default: ;
      endcase
      if (scr != SCR_NONE) expected_reports.push_back(make_report(scr, 1'b0));
      expected_reports.push_back(make_report(SCR_NONE, 1'b1));
      if (trk_touch) begin
        trk_last_touch = trk_ms;
        trk_countdown = cfg_release;
        trk_armed = 1'b1;
      end
    end
  endtask

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic string show_report(tpt_out_t r);
    return $sformatf("x=%0d y=%0d l=%b r=%b touch=%b scr(udlr)=%b%b%b%b last=%b",
                     r.pos_x_out, r.pos_y_out, r.left_button, r.right_button,
                     r.touching, r.scroll_up, r.scroll_down, r.scroll_left,
                     r.scroll_right, r.last_of_run);
  endfunction

  // Driver: presents the front of the request queue and holds it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      item_taken = in_valid && !in_stall;
      if (item_taken) begin
        predict_reports(in_data);
        void'(queued_requests.pop_front());
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
        end
      end
      if (in_valid && !item_taken) begin
        // Hold the stalled item as it is.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (queued_requests.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= queued_requests[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted report and stalls the output at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected report at cycle %0d: %s", cycle_count,
                     show_report(out_data));
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10)
              $display("report mismatch at cycle %0d: expected %s, got %s", cycle_count,
                       show_report(want), show_report(out_data));
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          if ($urandom_range(0, 1) == 1) stall_left = pick_gap();
          if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(40, 120);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic tpt_in_t packet(logic [7:0] st, logic [7:0] xb, logic [7:0] yb,
                                     logic [7:0] kind);
    tpt_in_t it;
    it.req_type = REQ_PACKET;
    it.status_byte = st;
    it.x_byte = xb;
    it.y_byte = yb;
    it.kind_byte = kind;
    return it;
  endfunction

  // A tick carries random bytes, which the block must ignore.
  task automatic push_ticks(int n);
    tpt_in_t it;
    for (int i = 0; i < n; i++) begin
      it.req_type = REQ_TICK;
      it.status_byte = 8'($urandom_range(0, 255));
      it.x_byte = 8'($urandom_range(0, 255));
      it.y_byte = 8'($urandom_range(0, 255));
      it.kind_byte = 8'($urandom_range(0, 255));
      queued_requests.push_back(it);
    end
  endtask

  function automatic tpt_in_t random_item();
    tpt_in_t it;
    int r;
    it.req_type = REQ_PACKET;
    it.status_byte = 8'($urandom_range(0, 255));
    it.x_byte = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 12));
    it.y_byte = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 12));
    r = $urandom_range(0, 99);
    if (r < 22) it.kind_byte = KIND_ABS;
    else if (r < 48) it.kind_byte = KIND_REL;
    else if (r < 52) it.kind_byte = KIND_SCR_UP;
    else if (r < 56) it.kind_byte = KIND_SCR_DOWN;
    else if (r < 60) it.kind_byte = KIND_SCR_LEFT;
    else if (r < 64) it.kind_byte = KIND_SCR_RIGHT;
    else if (r < 70) it.kind_byte = 8'($urandom_range(0, 255));
    else begin
      it.req_type = REQ_TICK;
      it.kind_byte = 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // Wait until every request is taken and every report has come, then let
  // trailing ticks work through the pipeline.
  task automatic wait_idle();
    while (queued_requests.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_X_SCALE: cfg_x_scale = value[7:0];
      CFG_Y_SCALE: cfg_y_scale = value[7:0];
      CFG_REL_GAIN: cfg_rel_gain = value[5:0];
      CFG_TAP_GAP: cfg_tap_gap = value[9:0];
      CFG_RELEASE_MS: cfg_release = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int xs, int ys, int gain, int tap, int rel);
    wait_idle();
    write_reg(CFG_X_SCALE, CFG_DATA_W'(xs));
    write_reg(CFG_Y_SCALE, CFG_DATA_W'(ys));
    write_reg(CFG_REL_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_TAP_GAP, CFG_DATA_W'(tap));
    write_reg(CFG_RELEASE_MS, CFG_DATA_W'(rel));
    @(negedge clk);
  endtask

  // Random packets and ticks; where the timers are short, one tick run is long
  // enough to release the finger and open the tap gap.
  task automatic run_random_phase(int count);
    int longest;
    longest = (int'(cfg_release) > int'(cfg_tap_gap)) ? int'(cfg_release)
                                                      : int'(cfg_tap_gap);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && longest < LONG_RUN_MAX) push_ticks(longest + 2);
      if ($urandom_range(0, 24) == 0) push_ticks(int'($urandom_range(2, 12)));
      queued_requests.push_back(random_item());
    end
  endtask

  initial begin
    reset_tracker();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items at the reset configuration.
    push_ticks(1);
    queued_requests.push_back(packet(8'h03, 8'hff, 8'h00, KIND_ABS));
    queued_requests.push_back(packet(8'h00, 8'h00, 8'hff, KIND_ABS));
    queued_requests.push_back(packet(8'hff, 8'h12, 8'h34, 8'h55));
    queued_requests.push_back(packet(8'h00, 8'hff, 8'h00, KIND_REL));
    queued_requests.push_back(packet(8'h10, 8'h01, 8'h00, KIND_REL));
    queued_requests.push_back(packet(8'h10, 8'h01, 8'h00, KIND_REL));
    queued_requests.push_back(packet(8'h20, 8'h00, 8'h01, KIND_REL));
    queued_requests.push_back(packet(8'h20, 8'h00, 8'h01, KIND_REL));
    queued_requests.push_back(packet(8'h20, 8'h00, 8'h01, KIND_REL));
    queued_requests.push_back(packet(8'h30, 8'h00, 8'h00, KIND_REL));
    queued_requests.push_back(packet(8'h11, 8'hff, 8'hff, KIND_REL));
    queued_requests.push_back(packet(8'h01, 8'h80, 8'hff, KIND_REL));
    queued_requests.push_back(packet(8'h00, 8'h40, 8'h40, KIND_ABS));
    queued_requests.push_back(packet(8'h02, 8'h00, 8'h00, KIND_SCR_UP));
    queued_requests.push_back(packet(8'h00, 8'hff, 8'hff, KIND_SCR_DOWN));
    queued_requests.push_back(packet(8'h01, 8'h55, 8'haa, KIND_SCR_LEFT));
    queued_requests.push_back(packet(8'hcc, 8'haa, 8'h55, KIND_SCR_RIGHT));
    queued_requests.push_back(packet(8'h03, 8'hff, 8'hff, 8'hff));
    queued_requests.push_back(packet(8'h03, 8'hff, 8'h00, KIND_REL));
    push_ticks(33);
    queued_requests.push_back(packet(8'h01, 8'h10, 8'h20, KIND_ABS));
    push_ticks(70);
    queued_requests.push_back(packet(8'hff, 8'h20, 8'h10, KIND_ABS));
    push_ticks(33);

    // Extreme settings, including a release time of zero.
    set_config(255, 255, 63, 0, 1);
    run_random_phase(PHASE_ITEMS);
    set_config(0, 0, 0, 1023, 1023);
    run_random_phase(PHASE_ITEMS);
    set_config(1, 1, 1, 5, 0);
    run_random_phase(PHASE_ITEMS);

    // Random settings with short timers.
    for (int p = 0; p < 2; p++) begin
      set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 63),
                 $urandom_range(0, 80), $urandom_range(1, 40));
      run_random_phase(PHASE_ITEMS);
    end

    set_config(X_SCALE_RST, Y_SCALE_RST, REL_GAIN_RST, TAP_GAP_RST, RELEASE_MS_RST);
    run_random_phase(PHASE_ITEMS);

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
